// ===== design/sbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsf_pkg
// Types, character codes and the letter shift shared by the framer's parts.
// ----------------------------------------------------------------------------
package sbsf_pkg;

	// framing characters
	localparam logic [7:0] CH_MARK = 8'h7A;   // 'z'
	localparam logic [7:0] CH_ESC  = 8'h78;   // 'x'
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;   // '0'

	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] UPPER_Z = 8'd90;
	localparam logic [7:0] LOWER_A = 8'd97;
	localparam logic [7:0] LOWER_Z = 8'd122;
	localparam logic [4:0] ALPHA_LEN = 5'd26;

	localparam logic [3:0]  REQ_MIN     = 4'd2;
	localparam logic [3:0]  REQ_MAX     = 4'd9;
	localparam logic [12:0] MAX_MESSAGE = 13'd4096;

	// register indexes on the configuration port
	localparam logic REG_CIPHER_ENABLE = 1'b0;
	localparam logic REG_SHIFT_AMOUNT  = 1'b1;

	typedef struct packed {
		logic       cipher_enable;
		logic [4:0] shift_amount;
	} cfg_t;

	// one classified input item, queued for the output sequencer
	typedef struct packed {
		logic       hdr;    // open a chunk: 'z' and length digit first
		logic [3:0] len;    // chunk length, 1..9
		logic       esc;    // data needs an escape in front
		logic [7:0] data;   // data byte after the shift
		logic       trl;    // close the chunk: 'z' and newline after
	} desc_t;

	typedef enum logic [2:0] {
		PH_MARK,
		PH_LEN,
		PH_ESC,
		PH_DATA,
		PH_TMARK,
		PH_NL
	} phase_t;

	// shift a letter by k (0..25) inside its own case; pass everything else
	function automatic logic [7:0] shift_letter(input logic [7:0] c, input logic [4:0] k);
		logic [7:0] base;
		logic       is_letter;
		logic [5:0] sum;
		base      = UPPER_A;
		is_letter = 1'b1;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			base = UPPER_A;
		end else if (c >= LOWER_A && c <= LOWER_Z) begin
			base = LOWER_A;
		end else begin
			is_letter = 1'b0;
		end
		sum = {1'b0, 5'(c - base)} + {1'b0, k};
		if (sum >= {1'b0, ALPHA_LEN}) begin
			sum = sum - {1'b0, ALPHA_LEN};
		end
		return is_letter ? (base + {2'b00, sum}) : c;
	endfunction

endpackage

// ===== design/shift_cipher_byte_stuffing_framer.sv =====
// ----------------------------------------------------------------------------
// shift_cipher_byte_stuffing_framer
// Caesar-shifts letters, cuts the byte stream into chunks with 'z' + length
// headers and 'z' + newline trailers, and escapes 'z' and 'x' with 'x'.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  s_axis    in   s_tvalid / s_tready     s_tdata: data_byte, chunk_request,
//                                         bytes_left
//  m_axis    out  m_tvalid / m_tready     m_tdata: out_byte; m_tlast: last_of_run
//  apb       in   psel / penable / pready 0x0 cipher_enable, 0x4 shift_amount
//
// Each input byte gives 1 to 6 output transfers, one per cycle unless m_tready
// stalls the output. A byte is taken whenever the descriptor queue has room,
// even while the output stalls; the first output byte of an item passes through
// the descriptor queue and then the output register.
// Reset clears the chunk state, the queue and both registers; no clearing pass.
// ----------------------------------------------------------------------------
module shift_cipher_byte_stuffing_framer import sbsf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] data_byte, [11:8] chunk_request,
	                               // [24:12] bytes_left, [31:25] zero
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  push;
	desc_t push_desc;
	desc_t head;
	logic  pop;
	logic  queue_full;
	logic  queue_empty;
	logic  [$bits(desc_t)-1:0] head_bits;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CIPHER_ENABLE: cfg_q.cipher_enable <= pwdata[0];
				REG_SHIFT_AMOUNT:  cfg_q.shift_amount  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CIPHER_ENABLE: prdata = {31'b0, cfg_q.cipher_enable};
			REG_SHIFT_AMOUNT:  prdata = {27'b0, cfg_q.shift_amount};
			default:           prdata = '0;
		endcase
	end

	sbsf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata[7:0]),
		.chunk_request(s_tdata[11:8]),
		.bytes_left   (s_tdata[24:12]),
		.push         (push),
		.push_desc    (push_desc),
		.queue_full   (queue_full)
	);

	sbsf_queue #(
		.WIDTH($bits(desc_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_desc),
		.pop      (pop),
		.head     (head_bits),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	assign head = desc_t'(head_bits);

	sbsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.queue_empty(queue_empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.last_of_run(m_tlast)
	);

endmodule

// ===== design/sbsf_queue.sv =====
// ----------------------------------------------------------------------------
// sbsf_queue
// Small register FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module sbsf_queue #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sbsf_front.sv =====
// ----------------------------------------------------------------------------
// sbsf_front
// Accepts message bytes, tracks the open chunk, applies the letter shift and
// classifies each byte into a descriptor for the output sequencer.
// ----------------------------------------------------------------------------
module sbsf_front import sbsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  chunk_request,
	input  logic [12:0] bytes_left,
	output logic        push,
	output desc_t       push_desc,
	input  logic        queue_full
);

	logic        frame_open_q;
	logic [3:0]  frame_remaining_q;
	logic        accept;
	logic [4:0]  key;
	logic [7:0]  data_sh;
	logic [3:0]  req_c;
	logic [12:0] left_c;
	logic [3:0]  len;
	logic [3:0]  rem_now;
	logic [3:0]  rem_next;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		key = (cfg.shift_amount >= ALPHA_LEN) ? cfg.shift_amount - ALPHA_LEN
		                                      : cfg.shift_amount;
		data_sh = cfg.cipher_enable ? shift_letter(data_byte, key) : data_byte;

		if (chunk_request < REQ_MIN) begin
			req_c = REQ_MIN;
		end else if (chunk_request > REQ_MAX) begin
			req_c = REQ_MAX;
		end else begin
			req_c = chunk_request;
		end
		if (bytes_left == '0) begin
			left_c = 13'd1;
		end else if (bytes_left > MAX_MESSAGE) begin
			left_c = MAX_MESSAGE;
		end else begin
			left_c = bytes_left;
		end
		len = ({9'b0, req_c} < left_c) ? req_c : left_c[3:0];

		rem_now  = frame_open_q ? frame_remaining_q : len;
		rem_next = rem_now - 1'b1;

		push_desc.hdr  = !frame_open_q;
		push_desc.len  = len;
		push_desc.esc  = (data_sh == CH_MARK) || (data_sh == CH_ESC);
		push_desc.data = data_sh;
		push_desc.trl  = (rem_next == '0);
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q      <= 1'b0;
			frame_remaining_q <= '0;
		end else if (accept) begin
			frame_open_q      <= !push_desc.trl;
			frame_remaining_q <= rem_next;
		end
	end

	a_open_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (frame_remaining_q != '0))
		else $error("open chunk with no bytes due");

endmodule

// ===== design/sbsf_back.sv =====
// ----------------------------------------------------------------------------
// sbsf_back
// Output sequencer: expands the queue head into marker, length, escape, data
// and trailer bytes, one per transfer, through an output register.
// ----------------------------------------------------------------------------
module sbsf_back import sbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      head,
	input  logic       queue_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic       busy_q;
	phase_t     phase_q;
	logic       m_valid_q;
	logic [7:0] m_byte_q;
	logic       m_last_q;
	logic       slot_free;
	logic       emit;
	phase_t     phase;
	phase_t     phase_next;
	logic [7:0] byte_now;
	logic       last_now;

	assign slot_free = !m_valid_q || out_ready;
	assign emit      = !queue_empty && slot_free;

	always_comb begin
		if (busy_q) begin
			phase = phase_q;
		end else if (head.hdr) begin
			phase = PH_MARK;
		end else if (head.esc) begin
			phase = PH_ESC;
		end else begin
			phase = PH_DATA;
		end

		byte_now   = head.data;
		last_now   = 1'b0;
		phase_next = PH_DATA;
		case (phase)
			PH_MARK: begin
				byte_now   = CH_MARK;
				phase_next = PH_LEN;
			end
			PH_LEN: begin
				byte_now   = CH_ZERO + {4'b0, head.len};
				phase_next = head.esc ? PH_ESC : PH_DATA;
			end
			PH_ESC: begin
				byte_now   = CH_ESC;
				phase_next = PH_DATA;
			end
			PH_DATA: begin
				byte_now   = head.data;
				last_now   = !head.trl;
				phase_next = PH_TMARK;
			end
			PH_TMARK: begin
				byte_now   = CH_MARK;
				phase_next = PH_NL;
			end
			PH_NL: begin
				byte_now   = CH_NL;
				last_now   = 1'b1;
				phase_next = PH_MARK;
			end
			default: begin
				byte_now   = head.data;
				last_now   = 1'b1;
				phase_next = PH_MARK;
			end
		endcase
	end

	// release the descriptor with its final byte
	assign pop = emit && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			phase_q   <= PH_MARK;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q  <= !last_now;
				phase_q <= phase_next;
			end
			if (slot_free) begin
				m_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_byte_q <= byte_now;
			m_last_q <= last_now;
		end
	end

	assign out_valid   = m_valid_q;
	assign out_byte    = m_byte_q;
	assign last_of_run = m_last_q;

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !queue_empty)
		else $error("sequencer mid-item with empty queue");

	a_len_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && phase == PH_LEN) |-> (byte_now >= 8'h31 && byte_now <= 8'h39))
		else $error("chunk length digit out of range");

	a_last_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_now) |-> (phase == PH_NL || (phase == PH_DATA && !head.trl)))
		else $error("end of run flagged in wrong phase");

endmodule
